// ===== sv/csx_pkg.sv =====
// ============================================================================
// csx_pkg - shared types and codes of the exclusive-time call-stack profiler
// Request codes, status codes and the control state encoding.
// ============================================================================
`default_nettype none

package csx_pkg;

  // Request codes carried on the input word
  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_END   = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // Status codes carried on the result word
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_OVERFLOW  = 3'd1;
  localparam logic [2:0] ST_UNDERFLOW = 3'd2;
  localparam logic [2:0] ST_BAD_ID    = 3'd3;
  localparam logic [2:0] ST_BACKWARD  = 3'd4;

  localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

  // Control state, one-hot
  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_EXEC  = 3'b100
  } ctrl_state_t;

endpackage

`default_nettype wire

// ===== sv/csx_ram.sv =====
// ============================================================================
// csx_ram - single-port-write, single-port-read synchronous memory
// One write and one registered read per cycle; read data holds until the
// next read enable.
// ============================================================================
`default_nettype none

module csx_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/call_stack_exclusive_time_core.sv =====
// ============================================================================
// call_stack_exclusive_time_core - exclusive-time call-stack profiler
// Tracks nested function activity from start/end events and keeps one
// saturating exclusive-time accumulator per function id.
// ============================================================================
//
//  channel | ports                                         | direction
//  --------+-----------------------------------------------+----------
//  input   | in_valid/in_ready, in_req_type, in_func_id,   | sink
//          | in_timestamp                                  |
//  result  | out_valid/out_ready, out_result_func,         | source
//          | out_exclusive_total, out_status               |
//
//  Each word passes an accept step and an execute step: the accept cycle
//  issues the reads of the accumulator table and the stack memory, the
//  execute step does the saturating add, writes both memories back and
//  loads the result register. The top of stack lives in a register so the
//  table address is known at accept time. After reset a clearing pass
//  zeroes every accumulator table entry; in_ready stays low meanwhile. A
//  stalled result holds the block in its execute cycle; a new word is
//  accepted while the last result still waits in the output register.
// ============================================================================
`default_nettype none

module call_stack_exclusive_time_core
  import csx_pkg::*;
#(
  parameter int NUM_FUNCS   = 256,
  parameter int STACK_DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [7:0]  in_func_id,
  input  wire logic [31:0] in_timestamp,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_result_func,
  output logic [31:0]      out_exclusive_total,
  output logic [2:0]       out_status
);

  localparam int TW = $clog2(NUM_FUNCS);       // table index width
  localparam int SW = $clog2(STACK_DEPTH);     // stack index width
  localparam int LW = $clog2(STACK_DEPTH + 1); // stack level width

  ctrl_state_t state_r, state_nxt;

  logic [TW-1:0] clr_idx_r;
  logic [LW-1:0] level_r, level_nxt;
  logic [31:0]   lb_r, lb_nxt;
  logic [7:0]    top_r, top_nxt;

  // latched input word
  logic [1:0]  req_r;
  logic [7:0]  id_r;
  logic [31:0] ts_r;

  // result register
  logic        out_valid_r;
  logic [7:0]  out_func_r, out_func_nxt;
  logic [31:0] out_total_r, out_total_nxt;
  logic [2:0]  out_status_r, out_status_nxt;

  logic accept;
  logic exec_fire;

  // memory ports
  logic          tbl_wr_en;
  logic [TW-1:0] tbl_wr_addr;
  logic [31:0]   tbl_wr_data;
  logic [TW-1:0] tbl_rd_addr;
  logic [31:0]   tbl_rd_data;
  logic          stk_wr_en;
  logic [7:0]    stk_rd_data;

  // execute-cycle arithmetic
  logic [TW-1:0] id_idx_in, top_idx;
  logic          bad_id, backward;
  logic [32:0]   delta;
  logic [33:0]   sum;
  logic [31:0]   sat_sum;
  logic          credit;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign exec_fire = (state_r == S_EXEC) && (!out_valid_r || out_ready);

  assign id_idx_in = TW'({{TW{1'b0}}, in_func_id});
  assign top_idx   = TW'({{TW{1'b0}}, top_r});

  // Credit the top function on start with a non-empty stack and on end
  always_comb begin
    if (((in_req_type == REQ_START) && (level_r != '0)) || (in_req_type == REQ_END)) begin
      tbl_rd_addr = top_idx;
    end else begin
      tbl_rd_addr = id_idx_in;
    end
  end

  csx_ram #(
    .DEPTH(NUM_FUNCS),
    .WIDTH(32)
  ) u_tbl (
    .clk    (clk),
    .wr_en  (tbl_wr_en),
    .wr_addr(tbl_wr_addr),
    .wr_data(tbl_wr_data),
    .rd_en  (accept),
    .rd_addr(tbl_rd_addr),
    .rd_data(tbl_rd_data)
  );

  // Read the entry below the top; it becomes the new top on a pop
  csx_ram #(
    .DEPTH(STACK_DEPTH),
    .WIDTH(8)
  ) u_stk (
    .clk    (clk),
    .wr_en  (exec_fire && stk_wr_en),
    .wr_addr(SW'(level_r)),
    .wr_data(id_r),
    .rd_en  (accept),
    .rd_addr(SW'(level_r - LW'(2))),
    .rd_data(stk_rd_data)
  );

  assign bad_id   = {24'd0, id_r} >= 32'(NUM_FUNCS);
  assign backward = ts_r < lb_r;

  // Elapsed time since last boundary; an end adds one tick
  always_comb begin
    delta = {1'b0, ts_r - lb_r};
    if (req_r == REQ_END) begin
      delta = delta + 33'd1;
    end
  end

  assign sum     = {2'b00, tbl_rd_data} + {1'b0, delta};
  assign sat_sum = (sum > {2'b00, TIME_MAX}) ? TIME_MAX : sum[31:0];

  // Execute-cycle decisions
  always_comb begin
    level_nxt      = level_r;
    lb_nxt         = lb_r;
    top_nxt        = top_r;
    out_func_nxt   = id_r;
    out_total_nxt  = 32'd0;
    out_status_nxt = ST_OK;
    credit         = 1'b0;
    stk_wr_en      = 1'b0;
    case (req_r)
      REQ_START: begin
        if (bad_id) begin
          out_status_nxt = ST_BAD_ID;
        end else if ({1'b0, level_r} >= (LW+1)'(STACK_DEPTH)) begin
          out_status_nxt = ST_OVERFLOW;
        end else if (backward) begin
          out_status_nxt = ST_BACKWARD;
        end else begin
          stk_wr_en = 1'b1;
          level_nxt = level_r + LW'(1);
          lb_nxt    = ts_r;
          top_nxt   = id_r;
          if (level_r == '0) begin
            out_total_nxt = tbl_rd_data;
          end else begin
            credit        = 1'b1;
            out_func_nxt  = top_r;
            out_total_nxt = sat_sum;
          end
        end
      end
      REQ_END: begin
        if (level_r == '0) begin
          out_func_nxt   = 8'd0;
          out_status_nxt = ST_UNDERFLOW;
        end else if (backward) begin
          out_func_nxt   = top_r;
          out_status_nxt = ST_BACKWARD;
        end else begin
          credit        = 1'b1;
          out_func_nxt  = top_r;
          out_total_nxt = sat_sum;
          level_nxt     = level_r - LW'(1);
          top_nxt       = stk_rd_data;
          lb_nxt        = (ts_r == TIME_MAX) ? TIME_MAX : ts_r + 32'd1;
        end
      end
      default: begin
        // read; the unused code decodes as a read too
        if (bad_id) begin
          out_status_nxt = ST_BAD_ID;
        end else begin
          out_total_nxt = tbl_rd_data;
        end
      end
    endcase
  end

  // Table write: zero sweep during clear, credit write-back otherwise
  always_comb begin
    if (state_r == S_CLEAR) begin
      tbl_wr_en   = 1'b1;
      tbl_wr_addr = clr_idx_r;
      tbl_wr_data = 32'd0;
    end else begin
      tbl_wr_en   = exec_fire && credit;
      tbl_wr_addr = top_idx;
      tbl_wr_data = sat_sum;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_idx_r == TW'(NUM_FUNCS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      level_r     <= '0;
      lb_r        <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_idx_r <= clr_idx_r + TW'(1);
      end
      if (exec_fire) begin
        level_r     <= level_nxt;
        lb_r        <= lb_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_req_type;
      id_r  <= in_func_id;
      ts_r  <= in_timestamp;
    end
    if (exec_fire) begin
      top_r        <= top_nxt;
      out_func_r   <= out_func_nxt;
      out_total_r  <= out_total_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_result_func     = out_func_r;
  assign out_exclusive_total = out_total_r;
  assign out_status          = out_status_r;

endmodule

`default_nettype wire

// ===== tb/call_stack_exclusive_time_checker.sv =====
// ============================================================================
// call_stack_exclusive_time_checker - result checker for the profiler core
// Watches both channels of the core and keeps its own copy of the call stack,
// boundary time and accumulator table. It predicts one result word per
// accepted input word and compares each result word, field by field, with
// the oldest prediction.
// ============================================================================

module call_stack_exclusive_time_checker
  import csx_pkg::*;
#(
  parameter int NUM_FUNCS   = 256,
  parameter int STACK_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [7:0]  in_func_id,
  input  logic [31:0] in_timestamp,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_result_func,
  input  logic [31:0] out_exclusive_total,
  input  logic [2:0]  out_status,
  output int unsigned mismatch_count,
  output int unsigned words_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [7:0]  func;
    logic [31:0] total;
    logic [2:0]  status;
  } profile_word_t;

  profile_word_t expected_words[$];
  logic [7:0]    call_ids [STACK_DEPTH];
  int unsigned   call_depth;
  logic [31:0]   boundary;
  logic [31:0]   excl_time [NUM_FUNCS];
  int unsigned   results_seen;

  // Add with a ceiling at the top of the 32-bit range.
  function automatic logic [31:0] sat_credit(logic [31:0] acc, logic [32:0] delta);
    logic [33:0] sum;
    sum = {2'b00, acc} + {1'b0, delta};
    return (sum > {2'b00, TIME_MAX}) ? TIME_MAX : sum[31:0];
  endfunction

  // Apply one event to the local profile and build the word it returns.
  task automatic profile_event(input logic [1:0] req, input logic [7:0] id,
                               input logic [31:0] ts, output profile_word_t res);
    logic [7:0] top;
    if (req == REQ_START) begin
      if (int'(id) >= NUM_FUNCS) begin
        res = '{id, 32'd0, ST_BAD_ID};
      end else if (call_depth >= STACK_DEPTH) begin
        res = '{id, 32'd0, ST_OVERFLOW};
      end else if (ts < boundary) begin
        res = '{id, 32'd0, ST_BACKWARD};
      end else if (call_depth == 0) begin
        // nothing runs yet: no credit, report the new id
        call_ids[0] = id;
        call_depth  = 1;
        boundary    = ts;
        res = '{id, excl_time[id], ST_OK};
      end else begin
        top = call_ids[call_depth - 1];
        excl_time[top] = sat_credit(excl_time[top], {1'b0, ts - boundary});
        call_ids[call_depth] = id;
        call_depth++;
        boundary = ts;
        res = '{top, excl_time[top], ST_OK};
      end
    end else if (req == REQ_END) begin
      if (call_depth == 0 || call_depth > STACK_DEPTH) begin
        res = '{8'd0, 32'd0, ST_UNDERFLOW};
      end else begin
        top = call_ids[call_depth - 1];
        if (ts < boundary) begin
          res = '{top, 32'd0, ST_BACKWARD};
        end else begin
          excl_time[top] = sat_credit(excl_time[top], {1'b0, ts - boundary} + 33'd1);
          call_depth--;
          boundary = (ts == TIME_MAX) ? TIME_MAX : ts + 32'd1;
          res = '{top, excl_time[top], ST_OK};
        end
      end
    end else begin
      // read; the spare request code decodes as a read too
      if (int'(id) >= NUM_FUNCS) res = '{id, 32'd0, ST_BAD_ID};
      else res = '{id, excl_time[id], ST_OK};
    end
  endtask

  task automatic flag_failure(input string what, input profile_word_t want,
                              input profile_word_t seen);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("%0t: %s at result word %0d:", $realtime, what, results_seen,
               " expected func=%02h total=%08h status=%0d,",
               want.func, want.total, want.status,
               " got func=%02h total=%08h status=%0d",
               seen.func, seen.total, seen.status);
  endtask

  always @(posedge clk) begin : watch
    profile_word_t seen;
    profile_word_t want;
    profile_word_t pred;
    if (!rst_n) begin
      expected_words.delete();
      foreach (call_ids[i]) call_ids[i] = '0;
      foreach (excl_time[i]) excl_time[i] = '0;
      call_depth     = 0;
      boundary       = '0;
      results_seen   = 0;
      mismatch_count = 0;
    end else begin
      // Retire the result first: a word accepted at this edge cannot be it.
      if (out_valid && out_ready) begin
        seen = '{out_result_func, out_exclusive_total, out_status};
        if (expected_words.size() == 0) begin
          flag_failure("unexpected result", '0, seen);
        end else begin
          want = expected_words.pop_front();
          if (seen.func !== want.func || seen.total !== want.total ||
              seen.status !== want.status)
            flag_failure("mismatch", want, seen);
        end
        results_seen++;
      end
      if (in_valid && in_ready) begin
        profile_event(in_req_type, in_func_id, in_timestamp, pred);
        expected_words.insert(expected_words.size(), pred);
      end
    end
    words_pending = expected_words.size();
  end

endmodule

// ===== tb/call_stack_exclusive_time_core_test.sv =====
// ============================================================================
// call_stack_exclusive_time_core_test - regression of the profiler core
// Drives start, end and read words into the core with bursty valid and a
// stalling result side, and lets a checker beside the core predict and
// compare every result word. Stimulus runs a short directed list, a long
// random stretch of nested calls, then a walk to the top of time that drives
// one accumulator into saturation.
// ============================================================================

module call_stack_exclusive_time_core_test
  import csx_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_FUNCS    = 256;
  localparam int STACK_DEPTH  = 64;
  localparam int RESET_CYCLES = 6;
  // Random words; the saturation walk at the end adds about as many again.
  localparam int RANDOM_WORDS = 600;
  // Cycles without any handshake before the run is declared hung. Covers the
  // table clearing pass after reset plus the longest result stall.
  localparam int IDLE_LIMIT   = 5000;
  localparam int DRAIN_CYCLES = 16;

  // Spare request code: the core decodes it as a read.
  localparam logic [1:0] REQ_SPARE = 2'd3;
  // Function ids used in the top-of-time walk.
  localparam logic [7:0] SAT_FUNC  = 8'hC3;
  localparam logic [7:0] JUMP_FUNC = 8'h3C;

  typedef enum logic [1:0] {
    READY_FULL,
    READY_MOSTLY,
    READY_HALF,
    READY_STARVED
  } ready_mode_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_req_type;
  logic [7:0]  in_func_id;
  logic [31:0] in_timestamp;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_result_func;
  logic [31:0] out_exclusive_total;
  logic [2:0]  out_status;

  int unsigned mismatch_count;
  int unsigned words_pending;

  // Handshake seen at the last rising edge, read back at the falling edge.
  logic        in_fire = 1'b0;
  int unsigned idle_cycles = 0;

  // Sender bookkeeping: stack depth and the earliest legal timestamp, kept
  // so that well-formed words stay well-formed and backward words are truly
  // backward.
  int unsigned depth_seen = 0;
  logic [31:0] cursor = '0;
  int unsigned burst_left = 0;

  ready_mode_t ready_mode = READY_FULL;
  int unsigned ready_left = 0;

  always begin
    #4ns clk = 1'b1;
    #4ns clk = 1'b0;
  end

  call_stack_exclusive_time_core #(
    .NUM_FUNCS  (NUM_FUNCS),
    .STACK_DEPTH(STACK_DEPTH)
  ) i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_req_type        (in_req_type),
    .in_func_id         (in_func_id),
    .in_timestamp       (in_timestamp),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_result_func    (out_result_func),
    .out_exclusive_total(out_exclusive_total),
    .out_status         (out_status)
  );

  call_stack_exclusive_time_checker #(
    .NUM_FUNCS  (NUM_FUNCS),
    .STACK_DEPTH(STACK_DEPTH)
  ) i_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_req_type        (in_req_type),
    .in_func_id         (in_func_id),
    .in_timestamp       (in_timestamp),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_result_func    (out_result_func),
    .out_exclusive_total(out_exclusive_total),
    .out_status         (out_status),
    .mismatch_count     (mismatch_count),
    .words_pending      (words_pending)
  );

  // Capture handshakes and run the hang watchdog. Any word moving on either
  // channel resets the idle count.
  always @(posedge clk) begin
    in_fire <= in_valid && in_ready;
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("call_stack_exclusive_time_core regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: switch between stretches of steady, patchy and starved
  // ready so stalls land on every phase of the core's accept and execute steps.
  always @(negedge clk) begin
    if (ready_left == 0) begin
      ready_mode <= ready_mode_t'($urandom_range(0, 3));
      ready_left <= $urandom_range(4, 48);
    end else begin
      ready_left <= ready_left - 1;
    end
    case (ready_mode)
      READY_FULL:    out_ready <= 1'b1;
      READY_MOSTLY:  out_ready <= ($urandom_range(0, 3) != 0);
      READY_HALF:    out_ready <= ($urandom_range(0, 1) != 0);
      READY_STARVED: out_ready <= ($urandom_range(0, 7) == 0);
      default:       out_ready <= 1'b1;
    endcase
  end

  // Mostly hot ids so accumulators build up, now and then any id.
  function automatic logic [7:0] pick_func();
    return ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
  endfunction

  // Present one word and hold it until accepted. Call at a falling edge;
  // returns at the falling edge right after the accepting rising edge.
  task automatic send_event(input logic [1:0] req, input logic [7:0] id,
                            input logic [31:0] ts);
    // Open a gap between bursts so valid never drops and rises in the same step.
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 24);
    end
    in_valid     <= 1'b1;
    in_req_type  <= req;
    in_func_id   <= id;
    in_timestamp <= ts;
    do @(negedge clk); while (!in_fire);
    burst_left--;
    // Track the stack depth and the boundary for legal follow-up words.
    if (req == REQ_START && depth_seen < STACK_DEPTH && ts >= cursor) begin
      depth_seen++;
      cursor = ts;
    end else if (req == REQ_END && depth_seen > 0 && ts >= cursor) begin
      depth_seen--;
      cursor = (ts == TIME_MAX) ? TIME_MAX : ts + 32'd1;
    end
  endtask

  initial begin : stimulus
    logic        diving;
    int unsigned phase_left;
    int unsigned pick;
    logic [31:0] step;
    logic [31:0] jump_from;

    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_req_type  = REQ_START;
    in_func_id   = '0;
    in_timestamp = '0;
    diving       = 1'b0;
    phase_left   = 0;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // Directed words. The core sits in its clearing pass first; send_event
    // just holds the word until in_ready rises.
    send_event(REQ_READ,  8'h00, 32'd0);           // cleared accumulator
    send_event(REQ_END,   8'h5A, 32'd0);           // end on empty stack
    send_event(REQ_START, 8'hFF, 32'd0);           // start on empty stack
    send_event(REQ_START, 8'h00, 32'd5);           // credit the caller
    send_event(REQ_END,   8'h00, 32'd4);           // end going back in time
    send_event(REQ_END,   8'hAA, 32'd9);           // end ignores its own id
    send_event(REQ_START, 8'h55, 32'd3);           // start going back in time
    send_event(REQ_END,   8'h00, 32'd10);
    send_event(REQ_END,   8'h00, 32'd10);          // underflow again
    send_event(REQ_READ,  8'hFF, TIME_MAX);
    send_event(REQ_SPARE, 8'h00, 32'h5555_5555);   // spare code reads
    send_event(REQ_START, 8'h80, 32'd12);
    send_event(REQ_START, 8'h80, 32'd12);          // recursion, zero credit
    send_event(REQ_END,   8'h00, 32'd12);
    send_event(REQ_END,   8'hFF, 32'd20);
    send_event(REQ_READ,  8'h80, 32'hAAAA_AAAA);

    // Random nesting. Alternate diving phases (mostly calls, hitting the
    // stack limit) with climbing phases (mostly returns, hitting empty).
    // Keep time steps small so the saturation walk at the end stays short.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (phase_left == 0) begin
        diving     = !diving;
        phase_left = $urandom_range(30, 140);
      end
      phase_left--;
      pick = $urandom_range(0, 99);
      step = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 9) : 32'd0;
      if (pick < 5 && cursor != 0) begin
        // broken event: timestamp behind the last boundary
        send_event(($urandom_range(0, 1) != 0) ? REQ_START : REQ_END, 8'($urandom),
                   $urandom_range(0, cursor - 1));
      end else if (pick < 8) begin
        send_event(REQ_SPARE, pick_func(), $urandom);
      end else if (pick < 20) begin
        send_event(REQ_READ, pick_func(), $urandom);
      end else if ($urandom_range(0, 99) < (diving ? 80 : 25)) begin
        send_event(REQ_START, pick_func(), cursor + step);
      end else begin
        send_event(REQ_END, 8'($urandom), cursor + step);
      end
    end

    // Top of time: unwind, park SAT_FUNC under a call that jumps to the
    // last tick, so it is credited with nearly the whole range. Then pin
    // the boundary at the last tick and add one tick per call/return pair
    // until the accumulator hits its ceiling and stays there.
    while (depth_seen > 0) send_event(REQ_END, 8'($urandom), cursor);
    jump_from = cursor;
    send_event(REQ_START, SAT_FUNC, jump_from);
    send_event(REQ_START, JUMP_FUNC, TIME_MAX);
    send_event(REQ_END,   8'h00, TIME_MAX);        // boundary holds at the top
    send_event(REQ_START, JUMP_FUNC, TIME_MAX - 32'd1);
    send_event(REQ_END,   8'h00, TIME_MAX - 32'd1);
    repeat (jump_from + 4) begin
      send_event(REQ_START, SAT_FUNC, TIME_MAX);
      send_event(REQ_END,   8'($urandom), TIME_MAX);
    end
    send_event(REQ_READ,  SAT_FUNC, $urandom);
    send_event(REQ_END,   8'h00, TIME_MAX);
    send_event(REQ_READ,  JUMP_FUNC, $urandom);

    in_valid <= 1'b0;

    // Wait for every predicted word, then a little longer to catch strays.
    // The watchdog ends the run if results stop coming.
    while (words_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_count == 0 && words_pending == 0) begin
      $display("call_stack_exclusive_time_core regression: pass");
    end else begin
      $display("call_stack_exclusive_time_core regression: fail");
    end
    $finish;
  end

endmodule
